// File: rtl/encoder_count_extender_macros.svh
// Assertion macros for the encoder count extender.
// Used inside modules that have clk and active-low rst_n in scope.
`ifndef ENCODER_COUNT_EXTENDER_MACROS_SVH
`define ENCODER_COUNT_EXTENDER_MACROS_SVH

// Same-cycle implication.
`define ECE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ECE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ece_pkg.sv
// Shared constants, codes and helpers for the encoder count extender.
// No dependencies.
`timescale 1ns / 1ps

package ece_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS_PER_REV = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READING_OFFSET = 8'd1;

    localparam logic [15:0] CPR_RESET = 16'd4000;

    localparam logic MODE_READ = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    localparam int STEP_COUNT = 16;
    localparam int STEP_W     = $clog2(STEP_COUNT);

    // Position bits for a rotary count: smallest P in 9..16 with 2^P >= cpr.
    function automatic logic [4:0] pos_bits(input logic [15:0] cpr);
        logic [4:0] pb;
        begin
            if (cpr == 16'd0)
                pb = 5'd16;
            else if (cpr <= 16'd512)
                pb = 5'd9;
            else if (cpr <= 16'd1024)
                pb = 5'd10;
            else if (cpr <= 16'd2048)
                pb = 5'd11;
            else if (cpr <= 16'd4096)
                pb = 5'd12;
            else if (cpr <= 16'd8192)
                pb = 5'd13;
            else if (cpr <= 16'd16384)
                pb = 5'd14;
            else if (cpr <= 16'd32768)
                pb = 5'd15;
            else
                pb = 5'd16;
            return pb;
        end
    endfunction

endpackage

// File: rtl/encoder_count_extender.sv
// Quadrature count extender: 16-bit hardware count to 32-bit position.
// Depends on ece_pkg and encoder_count_extender_macros.svh.
`timescale 1ns / 1ps

// One word at a time through a shared 32-bit adder under a small sequencer.
// A rotary read goes from accept through wrap check, setup, 16 shift-add
// steps for turns * counts_per_rev and output; a linear read goes through
// wrap check, setup and output. A rotary set runs 16 restoring divide steps of
// the angle by counts_per_rev, a quotient add and output; a linear set goes
// straight to output. Both loops run on the shared adder. s_tready
// is high only while no word is being worked on; a finished result sits in
// the output register, so the next word can be taken while it waits.
// Configuration writes are always accepted and belong to idle periods.

`include "encoder_count_extender_macros.svh"

module encoder_count_extender
    import ece_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // raw_count[15:0], set_turns[47:16], set_angle[63:48]
    input  logic [0:0]             s_tuser,   // mode
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [95:0]            m_tdata,   // turns[31:0], angle[47:32], reading[79:48],
                                              // load_count[95:80]
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_ADDQ,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [15:0]         cpr_reg;
    logic [31:0]         offset_reg;
    logic [15:0]         prev_reg;
    logic [31:0]         hp_reg;

    logic                mode_reg;
    logic [15:0]         cnt_reg;
    logic [31:0]         acc_reg;
    logic [31:0]         aux_reg;
    logic [15:0]         sh_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [31:0]         turns_reg;
    logic [15:0]         angle_reg;

    logic                m_tvalid_reg;
    logic [31:0]         out_turns_reg;
    logic [15:0]         out_angle_reg;
    logic [31:0]         out_reading_reg;
    logic [15:0]         out_load_reg;

    logic                in_fire;
    logic                out_free;
    logic                linear;
    logic [4:0]          pb;
    logic [2:0]          up_shift;
    logic [15:0]         mask;

    logic [31:0]         add_a;
    logic [31:0]         add_b;
    logic                add_cin;
    logic [31:0]         add_sum;

    logic [31:0]         hp_wrap_next;
    logic [15:0]         half;
    logic [31:0]         turns_next;
    logic [15:0]         angle_next;
    logic [31:0]         rem_trial;
    logic                div_neg;
    logic [15:0]         load_next;
    logic [31:0]         hp_set_next;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign linear   = (cpr_reg == 16'd0);
    assign pb       = pos_bits(cpr_reg);
    assign up_shift = 3'(5'd16 - pb);
    assign mask     = (pb >= 5'd16) ? 16'hFFFF : 16'((17'd1 << pb) - 17'd1);
    assign half     = cpr_reg >> 1;

    // wrap detection on the new sample
    always_comb
    begin
        hp_wrap_next = hp_reg;
        if (linear || pb <= 5'd14)
        begin
            if (cnt_reg[15:14] == 2'b11 && prev_reg[15:14] == 2'b00)
                hp_wrap_next = hp_reg - 32'd1;
            else if (cnt_reg[15:14] == 2'b00 && prev_reg[15:14] == 2'b11)
                hp_wrap_next = hp_reg + 32'd1;
        end
        else if (pb == 5'd15)
        begin
            // half-revolution rule for a 15-bit rotary count
            if (cnt_reg[15] && !prev_reg[15])
            begin
                if ({1'b0, cnt_reg[14:0]} >= half && {1'b0, prev_reg[14:0]} < half)
                    hp_wrap_next = hp_reg - 32'd1;
            end
            else if (!cnt_reg[15] && prev_reg[15])
            begin
                if ({1'b0, cnt_reg[14:0]} < half && {1'b0, prev_reg[14:0]} >= half)
                    hp_wrap_next = hp_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        if (linear)
        begin
            turns_next = {hp_reg[15:0], cnt_reg};
            angle_next = 16'd0;
        end
        else
        begin
            turns_next = (32'(cnt_reg) >> pb) | (hp_reg << up_shift);
            angle_next = cnt_reg & mask;
        end
    end

    assign rem_trial = {15'd0, acc_reg[15:0], sh_reg[15]};

    // shared adder operand selection
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = aux_reg;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_PREP:
            begin
                add_a = offset_reg;
                add_b = linear ? turns_next : {16'd0, angle_next};
            end
            ST_DIV:
            begin
                add_a   = rem_trial;
                add_b   = ~{16'd0, cpr_reg};
                add_cin = 1'b1;
            end
            ST_ADDQ:
            begin
                add_a = aux_reg;
                add_b = {16'd0, sh_reg};
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = aux_reg;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = add_a + add_b + {31'd0, add_cin};
    assign div_neg = add_sum[31];

    // set mode: split the normalized turns into counter and extension
    always_comb
    begin
        if (linear)
        begin
            load_next   = aux_reg[15:0];
            hp_set_next = aux_reg >> 16;
        end
        else
        begin
            load_next   = (acc_reg[15:0] & mask) | 16'(aux_reg << pb);
            hp_set_next = aux_reg >> up_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cpr_reg         <= CPR_RESET;
            offset_reg      <= 32'd0;
            prev_reg        <= 16'd0;
            hp_reg          <= 32'd0;
            m_tvalid_reg    <= 1'b0;
            step_reg        <= '0;
            mode_reg        <= MODE_READ;
            cnt_reg         <= 16'd0;
            acc_reg         <= 32'd0;
            aux_reg         <= 32'd0;
            sh_reg          <= 16'd0;
            turns_reg       <= 32'd0;
            angle_reg       <= 16'd0;
            out_turns_reg   <= 32'd0;
            out_angle_reg   <= 16'd0;
            out_reading_reg <= 32'd0;
            out_load_reg    <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_COUNTS_PER_REV)
                    cpr_reg <= cfg_data[15:0];
                else if (cfg_index == CFG_READING_OFFSET)
                    offset_reg <= cfg_data;
            end

            // a finishing word reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        mode_reg <= s_tuser[0];
                        cnt_reg  <= s_tdata[15:0];
                        aux_reg  <= s_tdata[47:16];
                        sh_reg   <= s_tdata[63:48];
                        acc_reg  <= 32'd0;
                        step_reg <= '0;
                        if (s_tuser[0] == MODE_READ)
                            state_reg <= ST_WRAP;
                        else if (cpr_reg == 16'd0)
                            state_reg <= ST_FIN;
                        else
                            state_reg <= ST_DIV;
                    end
                end
                ST_WRAP:
                begin
                    hp_reg    <= hp_wrap_next;
                    prev_reg  <= cnt_reg;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    turns_reg <= turns_next;
                    angle_reg <= angle_next;
                    acc_reg   <= add_sum;
                    aux_reg   <= turns_next;
                    sh_reg    <= cpr_reg;
                    step_reg  <= '0;
                    state_reg <= linear ? ST_FIN : ST_MUL;
                end
                ST_MUL:
                begin
                    if (sh_reg[0])
                        acc_reg <= add_sum;
                    aux_reg  <= aux_reg << 1;
                    sh_reg   <= sh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEP_COUNT - 1))
                        state_reg <= ST_FIN;
                end
                ST_DIV:
                begin
                    acc_reg  <= div_neg ? rem_trial : add_sum;
                    sh_reg   <= {sh_reg[14:0], !div_neg};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEP_COUNT - 1))
                        state_reg <= ST_ADDQ;
                end
                ST_ADDQ:
                begin
                    aux_reg   <= add_sum;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (mode_reg == MODE_READ)
                        begin
                            out_turns_reg   <= turns_reg;
                            out_angle_reg   <= angle_reg;
                            out_reading_reg <= acc_reg;
                            out_load_reg    <= cnt_reg;
                        end
                        else
                        begin
                            out_turns_reg   <= 32'd0;
                            out_angle_reg   <= 16'd0;
                            out_reading_reg <= 32'd0;
                            out_load_reg    <= load_next;
                            hp_reg          <= hp_set_next;
                            prev_reg        <= load_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_load_reg, out_reading_reg, out_angle_reg, out_turns_reg};

    `ECE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `ECE_ASSERT_NOW(a_result_from_fin, $rose(m_tvalid), $past(state_reg == ST_FIN), "stray result")
    `ECE_ASSERT_NOW(a_rem_below_cpr, state_reg == ST_DIV,
        (acc_reg[31:16] == 16'd0) && (acc_reg[15:0] < cpr_reg), "remainder not below cpr")
    `ECE_ASSERT_NOW(a_hp_update_point, !$stable(hp_reg),
        $past(state_reg == ST_WRAP) || $past(state_reg == ST_FIN), "extension changed off-step")

endmodule

// File: sim/encoder_count_extender_test.sv
// Self-checking bench for encoder_count_extender: directed and random count
// samples and position sets, checked word by word against an in-bench predictor.
// Depends on ece_pkg and the encoder_count_extender RTL.
`timescale 1ns / 1ps

module encoder_count_extender_test;
    import ece_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 28;
    localparam int STALL_CYCLES    = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'd2;

    typedef struct packed {
        logic [31:0] turns;
        logic [15:0] angle;
        logic [31:0] reading;
        logic [15:0] load_count;
    } position_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // raw_count[15:0], set_turns[47:16], set_angle[63:48]
    logic [0:0]             s_tuser;   // mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [95:0]            m_tdata;   // turns[31:0], angle[47:32], reading[79:48],
                                       // load_count[95:80]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    // predictor state
    logic [15:0] model_cpr;
    logic [31:0] model_offset;
    logic [15:0] last_sample;
    logic [31:0] high_turns;

    position_t expected_positions[$];

    int error_count      = 0;
    int read_words       = 0;
    int set_words        = 0;
    int checked_words    = 0;
    int settings_written = 0;
    int cycle_count      = 0;
    bit tx_idle          = 0;
    bit rx_idle          = 0;
    int rx_wait          = 0;
    int rx_hold          = 0;

    encoder_count_extender dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                     expected_positions.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned position_bits(input logic [15:0] cpr);
        int unsigned bits;
        if (cpr == 16'd0)
            return 16;
        bits = 9;
        while (bits < 16 && (32'd1 << bits) < {16'd0, cpr})
            bits++;
        return bits;
    endfunction

    // Advances the extension state by one accepted word and returns its result.
    function automatic position_t advance_encoder(input logic mode, input logic [15:0] raw,
                                                  input logic [31:0] new_turns,
                                                  input logic [15:0] new_angle);
        position_t   res;
        int unsigned pb;
        logic [31:0] mask;
        logic [31:0] half;
        logic [31:0] low_now;
        logic [31:0] low_prev;
        logic [31:0] revs;
        logic [31:0] quot;
        logic [31:0] rem;
        logic [31:0] packed_count;
        res  = '0;
        pb   = position_bits(model_cpr);
        mask = (pb >= 16) ? 32'h0000_FFFF : ((32'd1 << pb) - 32'd1);
        if (mode == MODE_READ)
        begin
            if (model_cpr == 16'd0 || pb <= 14)
            begin
                if (raw[15:14] == 2'b11 && last_sample[15:14] == 2'b00)
                    high_turns = high_turns - 32'd1;
                else if (raw[15:14] == 2'b00 && last_sample[15:14] == 2'b11)
                    high_turns = high_turns + 32'd1;
            end
            else if (pb == 15)
            begin
                // half-revolution rule for a 15-bit rotary count
                half     = {16'd0, model_cpr} / 32'd2;
                low_now  = {17'd0, raw[14:0]};
                low_prev = {17'd0, last_sample[14:0]};
                if (raw[15] && !last_sample[15])
                begin
                    if (low_now >= half && low_prev < half)
                        high_turns = high_turns - 32'd1;
                end
                else if (!raw[15] && last_sample[15])
                begin
                    if (low_now < half && low_prev >= half)
                        high_turns = high_turns + 32'd1;
                end
            end
            last_sample = raw;
            if (model_cpr == 16'd0)
            begin
                res.turns   = {high_turns[15:0], raw};
                res.reading = res.turns + model_offset;
            end
            else
            begin
                res.angle   = raw & mask[15:0];
                res.turns   = ({16'd0, raw} >> pb) | (high_turns << (16 - pb));
                res.reading = res.turns * {16'd0, model_cpr} + {16'd0, res.angle}
                              + model_offset;
            end
            res.load_count = raw;
        end
        else
        begin
            revs = new_turns;
            if (model_cpr == 16'd0)
            begin
                res.load_count = revs[15:0];
                high_turns     = revs >> 16;
            end
            else
            begin
                quot           = {16'd0, new_angle} / {16'd0, model_cpr};
                rem            = {16'd0, new_angle} - quot * {16'd0, model_cpr};
                revs           = revs + quot;
                packed_count   = (rem & mask) | (revs << pb);
                res.load_count = packed_count[15:0];
                high_turns     = revs >> (16 - pb);
            end
            last_sample = res.load_count;
        end
        return res;
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_word(input logic mode, input logic [15:0] raw,
                             input logic [31:0] turns_in, input logic [15:0] angle_in);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {angle_in, turns_in, raw};
        do
            @(posedge clk);
        while (!s_tready);
        expected_positions.push_back(advance_encoder(mode, raw, turns_in, angle_in));
        if (mode == MODE_READ)
            read_words++;
        else
            set_words++;
    endtask

    // Lowers valid and waits until every result is back and the block is quiet.
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_COUNTS_PER_REV)
            model_cpr = value[15:0];
        else if (index == CFG_READING_OFFSET)
            model_offset = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stray upper bits on the counts-per-rev write must be dropped by the block.
    task automatic configure(input logic [15:0] cpr, input logic [31:0] offset);
        settle_block();
        write_register(CFG_COUNTS_PER_REV, {16'($urandom), cpr});
        write_register(CFG_READING_OFFSET, offset);
        settings_written++;
    endtask

    // Reset setting (4000 counts, 12 position bits): top-two-bit wraps both ways.
    task automatic test_rotary_wrap();
        send_word(MODE_READ, 16'h0000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'hFFFF, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h0001, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h3FFF, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'hC000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h8000, 32'($urandom), 16'($urandom));
    endtask

    // Turn extremes, angle at and above counts per rev, then a read back.
    task automatic test_set_position();
        send_word(MODE_SET, 16'($urandom), 32'h7FFF_FFFF, model_cpr - 16'd1);
        send_word(MODE_SET, 16'($urandom), 32'h8000_0000, 16'hFFFF);
        send_word(MODE_SET, 16'($urandom), 32'h0000_0000, model_cpr);
        send_word(MODE_SET, 16'($urandom), 32'hFFFF_FFFF, 16'h0000);
        send_word(MODE_READ, 16'h0005, 32'($urandom), 16'($urandom));
    endtask

    task automatic test_linear_mode();
        configure(16'd0, 32'h7FFF_FFFF);
        send_word(MODE_READ, 16'h1234, 32'($urandom), 16'($urandom));
        send_word(MODE_SET, 16'($urandom), 32'h8000_FFFF, 16'($urandom));
        send_word(MODE_READ, 16'h0000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'hC000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h7FFF, 32'($urandom), 16'($urandom));
    endtask

    // 20000 counts: 15 position bits, half point at 10000.
    task automatic test_half_turn_rule();
        configure(16'd20000, 32'h8000_0000);
        send_word(MODE_SET, 16'($urandom), 32'd3, 16'd19999);
        send_word(MODE_READ, 16'd100, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h8000 | 16'd15000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'd15000, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h8000 | 16'd5000, 32'($urandom), 16'($urandom));
    endtask

    // Full 16-bit rotary count: no wrap tracking at all.
    task automatic test_wide_count();
        configure(16'd65535, 32'($urandom));
        send_word(MODE_READ, 16'hFFFF, 32'($urandom), 16'($urandom));
        send_word(MODE_READ, 16'h0000, 32'($urandom), 16'($urandom));
        send_word(MODE_SET, 16'($urandom), 32'd5, 16'hFFFF);
    endtask

    task automatic test_unmapped_register();
        settle_block();
        write_register(CFG_UNMAPPED, 32'($urandom));
        send_word(MODE_READ, 16'($urandom), 32'($urandom), 16'($urandom));
    endtask

    // Mostly smooth count motion with wraps, plus sets and occasional jumps.
    task automatic test_random_traffic();
        logic [15:0] cpr;
        logic [31:0] offset;
        logic [15:0] walk;
        logic [15:0] boundary;
        logic [15:0] new_angle;
        logic [31:0] new_turns;
        int          span;
        int          kind;
        int          step;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       cpr = 16'd0;
                1:       cpr = 16'd1;
                2:       cpr = 16'd512;
                3:       cpr = 16'd513;
                4:       cpr = 16'd4000;
                5:       cpr = 16'd16384;
                6:       cpr = 16'd16385;
                7:       cpr = 16'd32768;
                8:       cpr = 16'd32769;
                9:       cpr = 16'd65535;
                default: cpr = 16'($urandom_range(1, 65535));
            endcase
            case (phase % 4)
                0:       offset = 32'h7FFF_FFFF;
                1:       offset = 32'h8000_0000;
                2:       offset = 32'd0;
                default: offset = $urandom;
            endcase
            configure(cpr, offset);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            span    = $urandom_range(16, 6000);
            walk    = last_sample;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 15)
                begin
                    if ($urandom_range(0, 1) == 0)
                        new_turns = $urandom;
                    else
                        new_turns = 32'($urandom_range(0, 20)) - 32'd10;
                    if (cpr != 16'd0 && $urandom_range(0, 3) != 0)
                        new_angle = 16'($urandom_range(0, cpr - 1));
                    else
                        new_angle = 16'($urandom);
                    send_word(MODE_SET, 16'($urandom), new_turns, new_angle);
                    walk = last_sample;
                end
                else
                begin
                    if (kind < 22)
                        walk = 16'($urandom);
                    else if (kind < 32)
                    begin
                        case ($urandom_range(0, 5))
                            0:       boundary = 16'h0000;
                            1:       boundary = 16'h4000;
                            2:       boundary = 16'h8000;
                            3:       boundary = 16'hC000;
                            4:       boundary = cpr >> 1;
                            default: boundary = 16'h8000 + (cpr >> 1);
                        endcase
                        walk = boundary + 16'($urandom_range(0, 64)) - 16'd32;
                    end
                    else
                    begin
                        step = $urandom_range(0, 2 * span) - span;
                        walk = walk + step[15:0];
                    end
                    send_word(MODE_READ, walk, 32'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    // Receiver stops for a long stretch while the sender keeps offering words.
    task automatic test_back_pressure();
        logic [15:0] walk;
        int          step;
        configure(16'd4000, 32'($urandom));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        walk    = last_sample;
        @(posedge clk);
        rx_hold = STALL_CYCLES;
        for (int n = 0; n < 40; n++)
        begin
            if (n % 5 == 4)
            begin
                send_word(MODE_SET, 16'($urandom), 32'($urandom),
                          16'($urandom_range(0, 3999)));
                walk = last_sample;
            end
            else
            begin
                step = $urandom_range(0, 1000) - 500;
                walk = walk + step[15:0];
                send_word(MODE_READ, walk, 32'($urandom), 16'($urandom));
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        logic [31:0] got_turns;
        logic [15:0] got_angle;
        logic [31:0] got_reading;
        logic [15:0] got_load;
        position_t   want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_turns   = m_tdata[31:0];
            got_angle   = m_tdata[47:32];
            got_reading = m_tdata[79:48];
            got_load    = m_tdata[95:80];
            rx_wait     = rx_idle ? $urandom_range(0, 15) : 0;
            if (expected_positions.size() == 0)
                report_failure($sformatf("result word with nothing outstanding: %h", m_tdata));
            else
            begin
                want = expected_positions.pop_front();
                checked_words++;
                if (got_turns !== want.turns)
                    report_failure($sformatf("turns: got %h expected %h",
                                             got_turns, want.turns));
                if (got_angle !== want.angle)
                    report_failure($sformatf("angle: got %h expected %h",
                                             got_angle, want.angle));
                if (got_reading !== want.reading)
                    report_failure($sformatf("reading: got %h expected %h",
                                             got_reading, want.reading));
                if (got_load !== want.load_count)
                    report_failure($sformatf("load_count: got %h expected %h",
                                             got_load, want.load_count));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        model_cpr    = CPR_RESET;
        model_offset = 32'd0;
        last_sample  = 16'd0;
        high_turns   = 32'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_rotary_wrap();
        test_set_position();
        test_linear_mode();
        test_half_turn_rule();
        test_wide_count();
        test_unmapped_register();
        test_random_traffic();
        test_back_pressure();
        settle_block();

        $display("Checked %0d result words from %0d count samples and %0d position sets,",
                 checked_words, read_words, set_words);
        $display("over %0d register settings: linear, 9..16 bit rotary, offset extremes.",
                 settings_written);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
